@@ hdl/hds_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package hds_pkg;

  localparam int NumRounds = 64;

  typedef struct packed {
    logic        mode;
    logic [31:0] nonce;
    logic [63:0] digest_ab;
    logic [63:0] digest_cd;
    logic [63:0] digest_ef;
    logic [63:0] digest_gh;
  } in_item_t;

  typedef struct packed {
    logic [63:0] hash_ab;
    logic [63:0] hash_cd;
    logic [63:0] hash_ef;
    logic [63:0] hash_gh;
  } out_item_t;

  typedef logic [7:0][31:0]  state_t;
  typedef logic [15:0][31:0] window_t;

  typedef enum logic [2:0] {
    REG_MIDSTATE_A = 3'd0,
    REG_MIDSTATE_B = 3'd1,
    REG_MIDSTATE_C = 3'd2,
    REG_MIDSTATE_D = 3'd3,
    REG_TAIL_AB    = 3'd4,
    REG_TAIL_C     = 3'd5
  } reg_index_t;

  localparam logic [31:0] PadWord = 32'h80000000;
  localparam logic [31:0] LenFirst = 32'd640;
  localparam logic [31:0] LenSecond = 32'd256;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam state_t InitState = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

@@ hdl/header_double_sha256_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Double-SHA-256 header engine, one fully unrolled compression.
// Input channel (in_valid/in_stall/in_data): mode 0 hashes the second header
// block from the configured midstate with the byte-swapped nonce; mode 1
// hashes the eight digest words from the standard initial state.
// Output channel (out_valid/out_stall/out_data): eight result words.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes midstate
// and tail registers; write only while no request is in flight.
// Pipeline: block setup stage, 64 round stages, feed-forward output stage.
// Throughput: one request per cycle unless a full output register is stalled,
// set by the single round register per SHA-256 round.
// A stall on a full output register freezes the whole pipeline; in_stall follows
// out_stall when the output register is full, so nothing is lost.
// Reset (rst, synchronous) clears all valid bits and config registers.
module header_double_sha256_top
  import hds_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_item_t       out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [63:0] cfg_data
);

  logic [63:0] midstate_a, midstate_b, midstate_c, midstate_d, tail_words_ab;
  logic [31:0] tail_word_c;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      midstate_a <= '0; midstate_b <= '0; midstate_c <= '0; midstate_d <= '0;
      tail_words_ab <= '0; tail_word_c <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIDSTATE_A: midstate_a <= cfg_data;
        REG_MIDSTATE_B: midstate_b <= cfg_data;
        REG_MIDSTATE_C: midstate_c <= cfg_data;
        REG_MIDSTATE_D: midstate_d <= cfg_data;
        REG_TAIL_AB:    tail_words_ab <= cfg_data;
        REG_TAIL_C:     tail_word_c <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // whole pipe moves together; hold when output register full and stalled
  logic advance;
  assign advance = !(out_valid && out_stall);
  assign in_stall = !advance;

  logic    v0;
  state_t  st0;
  window_t win0;
  state_t  st_sel;
  window_t win_sel;
  logic [31:0] nsw;

  always_comb begin
    nsw = {in_data.nonce[7:0], in_data.nonce[15:8], in_data.nonce[23:16],
           in_data.nonce[31:24]};
    win_sel = '0;
    if (!in_data.mode) begin
      st_sel = {midstate_d[31:0], midstate_d[63:32], midstate_c[31:0], midstate_c[63:32],
                midstate_b[31:0], midstate_b[63:32], midstate_a[31:0], midstate_a[63:32]};
      win_sel[0] = tail_words_ab[63:32];
      win_sel[1] = tail_words_ab[31:0];
      win_sel[2] = tail_word_c;
      win_sel[3] = nsw;
      win_sel[4] = PadWord;
      win_sel[15] = LenFirst;
    end else begin
      st_sel = InitState;
      win_sel[0] = in_data.digest_ab[63:32];
      win_sel[1] = in_data.digest_ab[31:0];
      win_sel[2] = in_data.digest_cd[63:32];
      win_sel[3] = in_data.digest_cd[31:0];
      win_sel[4] = in_data.digest_ef[63:32];
      win_sel[5] = in_data.digest_ef[31:0];
      win_sel[6] = in_data.digest_gh[63:32];
      win_sel[7] = in_data.digest_gh[31:0];
      win_sel[8] = PadWord;
      win_sel[15] = LenSecond;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (advance) begin
      v0 <= in_valid;
    end
    if (advance) begin
      st0  <= st_sel;
      win0 <= win_sel;
    end
  end

  logic    rv  [NumRounds+1];
  state_t  rst_s [NumRounds+1];
  state_t  rbase [NumRounds+1];
  window_t rwin [NumRounds+1];

  assign rv[0] = v0;
  assign rst_s[0] = st0;
  assign rbase[0] = st0;
  assign rwin[0] = win0;

  for (genvar r = 0; r < NumRounds; r++) begin : g_round
    hds_round #(.Round(r)) u_round (
      .clk(clk), .rst(rst), .advance(advance),
      .valid_in(rv[r]), .st_in(rst_s[r]), .base_in(rbase[r]), .win_in(rwin[r]),
      .valid(rv[r+1]), .st(rst_s[r+1]), .base(rbase[r+1]), .win(rwin[r+1])
    );
  end

  state_t fin;
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      fin[i] = rst_s[NumRounds][i] + rbase[NumRounds][i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= rv[NumRounds];
    end
    if (advance) begin
      out_data <= {fin[0], fin[1], fin[2], fin[3], fin[4], fin[5], fin[6], fin[7]};
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed under stall");
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall mismatch");
  a_frozen: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(rv[NumRounds]) && $stable(v0))
    else $error("pipe moved while held");

endmodule
`default_nettype wire

@@ hdl/hds_round.sv @@
`timescale 1ns / 1ps
`default_nettype none
module hds_round
  import hds_pkg::*;
#(
  parameter int Round = 0
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    advance,
  input  wire logic    valid_in,
  input  wire state_t  st_in,
  input  wire state_t  base_in,
  input  wire window_t win_in,
  output logic         valid,
  output state_t       st,
  output state_t       base,
  output window_t      win
);

  logic [31:0] t1, t2, ch, mj, s0, s1, w_new;
  logic [31:0] a, b, c, e, f, g, h;
  state_t st_next;

  assign a = st_in[0];
  assign b = st_in[1];
  assign c = st_in[2];
  assign e = st_in[4];
  assign f = st_in[5];
  assign g = st_in[6];
  assign h = st_in[7];

  always_comb begin
    ch = (e & f) ^ (~e & g);
    mj = (a & b) ^ (a & c) ^ (b & c);
    t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ch + RoundK[Round] + win_in[0];
    t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + mj;
    st_next = {st_in[6:4], st_in[3] + t1, st_in[2:0], t1 + t2};
    // schedule word for index Round+16, from window positions 0,1,9,14
    s0 = rotr(win_in[1], 7) ^ rotr(win_in[1], 18) ^ (win_in[1] >> 3);
    s1 = rotr(win_in[14], 17) ^ rotr(win_in[14], 19) ^ (win_in[14] >> 10);
    w_new = win_in[0] + s0 + win_in[9] + s1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= valid_in;
    end
    if (advance) begin
      st   <= st_next;
      base <= base_in;
      win  <= {w_new, win_in[15:1]};
    end
  end

endmodule
`default_nettype wire
